// File: hw/rtl/dee_pkg.sv
// ----------------------------------------------------------------------------
// dee_pkg
// Shared types and codes for the data EEPROM controller.
// ----------------------------------------------------------------------------
package dee_pkg;

   // Controller sequencing states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH
   } state_type;

   // Command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Register selects
   localparam logic [2:0] SEL_ADDR_LOW  = 3'd0;
   localparam logic [2:0] SEL_ADDR_HIGH = 3'd1;
   localparam logic [2:0] SEL_DATA      = 3'd2;
   localparam logic [2:0] SEL_CONTROL   = 3'd3;
   localparam logic [2:0] SEL_UNLOCK    = 3'd4;

   // Control register bits
   localparam logic [7:0] CTL_PGM  = 8'h80;
   localparam logic [7:0] CTL_CFG  = 8'h40;
   localparam logic [7:0] CTL_WREN = 8'h04;
   localparam logic [7:0] CTL_WR   = 8'h02;
   localparam logic [7:0] CTL_RD   = 8'h01;

   // Unlock sequence
   localparam logic [7:0] UNLOCK_KEY_FIRST  = 8'h55;
   localparam logic [7:0] UNLOCK_KEY_SECOND = 8'hAA;
   localparam logic [1:0] UNLOCK_LOCKED     = 2'd0;
   localparam logic [1:0] UNLOCK_ARMED      = 2'd1;
   localparam logic [1:0] UNLOCK_OPEN       = 2'd2;

   // Configuration registers
   localparam logic       CSR_WRITE_TICKS   = 1'b0;
   localparam logic [15:0] WRITE_TICKS_RESET = 16'd64;

   // Erased byte value
   localparam logic [7:0] ERASED_BYTE = 8'hFF;

endpackage

// File: hw/rtl/data_eeprom_controller.sv
// ----------------------------------------------------------------------------
// data_eeprom_controller
// Byte-wide register front end of a data EEPROM with an unlock sequence.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                       | handshake
//  ----------+---------------------------------------------+---------------------------
//  request   | req_command, req_reg_select, req_write_data | taken when start & !busy
//  response  | rsp_read_data, rsp_busy_res                 | one-cycle rsp_valid strobe
//  config    | psel penable pwrite paddr pwdata prdata     | APB write, pready tied high
//
// A request word is taken in each idle cycle with start high, but a control write
// that sets the read bit in data space also passes through the fetch state, since
// the store's read port is registered (busy stays high in the fetch state).
// The response word is registered and appears in the cycle after the request is accepted.
// After reset the store is erased to 0xFF, one byte per cycle, and busy stays
// high until the sweep is done; config writes are taken during the sweep.
// The response side has no back pressure: the strobe lasts one cycle.
// ----------------------------------------------------------------------------
module data_eeprom_controller #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_reg_select,
   input  logic [7:0]  req_write_data,
   // response channel
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_busy_res,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam logic [10:0] DEPTH_W = 11'(STORE_DEPTH);

   // sequencer
   dee_pkg::state_type state_ff;
   dee_pkg::state_type state_in;

   // architectural registers
   logic [7:0]        addr_low_ff,   addr_low_in;
   logic [1:0]        addr_high_ff,  addr_high_in;
   logic [7:0]        data_ff,       data_in;
   logic [7:0]        control_ff,    control_in;
   logic [1:0]        unlock_ff,     unlock_in;
   logic [15:0]       countdown_ff,  countdown_in;
   logic [ADDR_W-1:0] pend_addr_ff,  pend_addr_in;
   logic [7:0]        pend_byte_ff,  pend_byte_in;
   logic [15:0]       write_ticks_ff;
   logic              fetch_pend_ff, fetch_pend_in;

   // response registers
   logic              rsp_valid_ff;
   logic [7:0]        rsp_read_data_ff, rsp_read_data_in;
   logic              rsp_busy_res_ff;

   // working signals
   logic              accept;
   logic              csr_write;
   logic [10:0]       red0, red1, red2, red3;
   logic [ADDR_W-1:0] byte_addr;
   logic [7:0]        kept;
   logic              data_space;
   logic              countdown_nz;
   logic [15:0]       ticks_eff;
   logic              mem_rd_en;
   logic              mem_wr_en;
   logic [7:0]        mem_rd_data;
   logic              init_done;

   // ---------------------------------------------------------------------
   // Byte store with erase sweep
   // ---------------------------------------------------------------------
   dee_mem #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (mem_rd_en),
      .rd_addr   (byte_addr),
      .rd_data   (mem_rd_data),
      .wr_en     (mem_wr_en),
      .wr_addr   (pend_addr_ff),
      .wr_data   (pend_byte_ff),
      .init_done (init_done)
   );

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready
                      & (paddr[2] == dee_pkg::CSR_WRITE_TICKS);

   always_comb begin
      prdata = '0;
      if (paddr[2] == dee_pkg::CSR_WRITE_TICKS) begin
         prdata = {16'b0, write_ticks_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ticks_ff <= dee_pkg::WRITE_TICKS_RESET;
      end else if (csr_write) begin
         write_ticks_ff <= pwdata[15:0];
      end
   end

   // ---------------------------------------------------------------------
   // Byte address: {high, low} folded into the store depth. The raw value
   // is below 1024 and the depth at least 256, so three conditional
   // subtractions always land in range.
   // ---------------------------------------------------------------------
   always_comb begin
      red0      = {1'b0, addr_high_ff, addr_low_ff};
      red1      = (red0 >= DEPTH_W) ? red0 - DEPTH_W : red0;
      red2      = (red1 >= DEPTH_W) ? red1 - DEPTH_W : red1;
      red3      = (red2 >= DEPTH_W) ? red2 - DEPTH_W : red2;
      byte_addr = red3[ADDR_W-1:0];
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dee_pkg::ST_CLEAR: begin
            if (init_done) begin
               state_in = dee_pkg::ST_IDLE;
            end
         end
         dee_pkg::ST_IDLE: begin
            // a data-space read holds the request side for the memory cycle
            if (mem_rd_en) begin
               state_in = dee_pkg::ST_FETCH;
            end
         end
         dee_pkg::ST_FETCH: begin
            state_in = dee_pkg::ST_IDLE;
         end
         default: begin
            state_in = dee_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      case (state_ff)
         dee_pkg::ST_IDLE: busy = 1'b0;
         default:          busy = 1'b1;
      endcase
   end

   assign accept = start & ~busy;

   // ---------------------------------------------------------------------
   // Register file update
   // ---------------------------------------------------------------------
   assign countdown_nz = countdown_ff != 16'd0;
   assign ticks_eff    = (write_ticks_ff == 16'd0) ? 16'd1 : write_ticks_ff;
   assign data_space   = (req_write_data & (dee_pkg::CTL_PGM | dee_pkg::CTL_CFG)) == 8'h00;

   always_comb begin
      addr_low_in      = addr_low_ff;
      addr_high_in     = addr_high_ff;
      data_in          = data_ff;
      control_in       = control_ff;
      unlock_in        = unlock_ff;
      countdown_in     = countdown_ff;
      pend_addr_in     = pend_addr_ff;
      pend_byte_in     = pend_byte_ff;
      fetch_pend_in    = 1'b0;
      rsp_read_data_in = 8'h00;
      mem_rd_en        = 1'b0;
      mem_wr_en        = 1'b0;
      kept             = req_write_data
                         & (dee_pkg::CTL_PGM | dee_pkg::CTL_CFG | dee_pkg::CTL_WREN);

      if (accept) begin
         case (req_command)
            dee_pkg::CMD_READ: begin
               case (req_reg_select)
                  dee_pkg::SEL_ADDR_LOW:  rsp_read_data_in = addr_low_ff;
                  dee_pkg::SEL_ADDR_HIGH: rsp_read_data_in = {6'b0, addr_high_ff};
                  dee_pkg::SEL_DATA:      rsp_read_data_in = data_ff;
                  dee_pkg::SEL_CONTROL:   rsp_read_data_in = control_ff;
                  default:                rsp_read_data_in = 8'h00;
               endcase
            end
            dee_pkg::CMD_WRITE: begin
               // any write outside the unlock register relocks
               unlock_in = dee_pkg::UNLOCK_LOCKED;
               case (req_reg_select)
                  dee_pkg::SEL_UNLOCK: begin
                     if (req_write_data == dee_pkg::UNLOCK_KEY_FIRST) begin
                        unlock_in = dee_pkg::UNLOCK_ARMED;
                     end else if (req_write_data == dee_pkg::UNLOCK_KEY_SECOND
                                  && unlock_ff == dee_pkg::UNLOCK_ARMED) begin
                        unlock_in = dee_pkg::UNLOCK_OPEN;
                     end
                  end
                  dee_pkg::SEL_ADDR_LOW:  addr_low_in  = req_write_data;
                  dee_pkg::SEL_ADDR_HIGH: addr_high_in = req_write_data[1:0];
                  dee_pkg::SEL_DATA:      data_in      = req_write_data;
                  dee_pkg::SEL_CONTROL: begin
                     if (countdown_nz) begin
                        kept = kept | dee_pkg::CTL_WR;
                     end
                     // fetch the byte; data lands in the fetch cycle
                     if (data_space && (req_write_data & dee_pkg::CTL_RD) != 8'h00) begin
                        mem_rd_en = 1'b1;
                     end
                     if (data_space && !countdown_nz
                         && (req_write_data & dee_pkg::CTL_WR) != 8'h00
                         && (req_write_data & dee_pkg::CTL_WREN) != 8'h00
                         && unlock_ff == dee_pkg::UNLOCK_OPEN) begin
                        pend_addr_in  = byte_addr;
                        pend_byte_in  = data_ff;
                        fetch_pend_in = mem_rd_en;
                        countdown_in  = ticks_eff;
                        kept          = kept | dee_pkg::CTL_WR;
                     end
                     control_in = kept;
                  end
                  default: begin
                  end
               endcase
            end
            dee_pkg::CMD_TICK: begin
               if (countdown_nz) begin
                  countdown_in = countdown_ff - 16'd1;
                  // last tick: commit the byte and drop the write bit
                  if (countdown_ff == 16'd1) begin
                     mem_wr_en  = 1'b1;
                     control_in = control_ff & ~dee_pkg::CTL_WR;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // fetch cycle: take the read byte, and latch it as the write byte too
      // when the same control write also started a byte write
      if (state_ff == dee_pkg::ST_FETCH) begin
         data_in = mem_rd_data;
         if (fetch_pend_ff) begin
            pend_byte_in = mem_rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dee_pkg::ST_CLEAR;
         addr_low_ff   <= 8'h00;
         addr_high_ff  <= 2'b00;
         data_ff       <= 8'h00;
         control_ff    <= 8'h00;
         unlock_ff     <= dee_pkg::UNLOCK_LOCKED;
         countdown_ff  <= 16'd0;
         pend_addr_ff  <= '0;
         pend_byte_ff  <= 8'h00;
         fetch_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_low_ff   <= addr_low_in;
         addr_high_ff  <= addr_high_in;
         data_ff       <= data_in;
         control_ff    <= control_in;
         unlock_ff     <= unlock_in;
         countdown_ff  <= countdown_in;
         pend_addr_ff  <= pend_addr_in;
         pend_byte_ff  <= pend_byte_in;
         fetch_pend_ff <= fetch_pend_in;
         rsp_valid_ff  <= accept;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_busy_res_ff  <= countdown_in != 16'd0;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_busy_res  = rsp_busy_res_ff;

endmodule

// File: hw/rtl/dee_mem.sv
// ----------------------------------------------------------------------------
// dee_mem
// Byte store: one write port, one registered read port, erase sweep on reset.
// ----------------------------------------------------------------------------
module dee_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   output logic              init_done
);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] clear_ptr_ff;
   logic [ADDR_W-1:0] clear_ptr_in;
   logic              clearing_ff;
   logic              clearing_in;
   logic              wr_sel;
   logic [ADDR_W-1:0] wr_sel_addr;
   logic [7:0]        wr_sel_data;

   // advance the erase pointer until the last entry is written
   always_comb begin
      clear_ptr_in = clear_ptr_ff;
      clearing_in  = clearing_ff;
      if (clearing_ff) begin
         if (clear_ptr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clear_ptr_in = clear_ptr_ff + ADDR_W'(1);
         end
      end
   end

   always_comb begin
      wr_sel      = clearing_ff | wr_en;
      wr_sel_addr = clearing_ff ? clear_ptr_ff : wr_addr;
      wr_sel_data = clearing_ff ? dee_pkg::ERASED_BYTE : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff <= '0;
         clearing_ff  <= 1'b1;
      end else begin
         clear_ptr_ff <= clear_ptr_in;
         clearing_ff  <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         mem[wr_sel_addr] <= wr_sel_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign init_done = ~clearing_ff;

endmodule
